/* rtl/ranked_node_top_k_macros.svh */
// Assertion macros shared by the ranked node top-k checker.
`ifndef RANKED_NODE_TOP_K_MACROS_SVH
`define RANKED_NODE_TOP_K_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RNTK_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RNTK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rntk_pkg.sv */
// Types, constants and helper functions shared by the ranked node top-k block.
package rntk_pkg;

  // Input item: one command with the fields of one node.
  typedef struct packed {
    logic [1:0]  mode;
    logic        live;
    logic [31:0] node_index;
    logic [3:0]  kind;
    logic [2:0]  flags;
    logic [16:0] confidence;
    logic [16:0] utility;
    logic [16:0] novelty;
    logic [16:0] risk;
    logic [16:0] cost;
  } in_item_t;

  // Result item: one kept entry of the finished list.
  typedef struct packed {
    logic        valid_res;
    logic [31:0] out_index;
    logic [15:0] out_rank;
    logic        truncated;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       clear;
    logic [2:0] step;
    logic       bp_en;
    logic       acc_en;
    logic       insert;
    logic       emit_start;
    logic       emit_load;
  } rntk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic at_last;
  } rntk_status_t;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_OFFER  = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  // Rank sequencer steps, one fraction per step; the final step only adds.
  localparam logic [2:0] STEP_CONF = 3'd0;
  localparam logic [2:0] STEP_UTIL = 3'd1;
  localparam logic [2:0] STEP_NOV  = 3'd2;
  localparam logic [2:0] STEP_RISK = 3'd3;
  localparam logic [2:0] STEP_COST = 3'd4;
  localparam logic [2:0] STEP_LAST = 3'd5;

  // Keep limit register.
  localparam int unsigned LIMIT_WIDTH = 5;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 5'd16;

  // Basis point conversion.
  localparam logic [13:0] BP_FULL  = 14'd10000;
  localparam logic [29:0] BP_ROUND = 30'd32768;
  // 21846 / 65536 gives an exact floor of x / 3 for x below 32768.
  localparam logic [15:0] THIRD_RECIP = 16'd21846;

  // Flag terms and the largest rank a node can reach.
  localparam logic [15:0] OPEN_BONUS     = 16'd5000;
  localparam logic [15:0] BLOCKED_BONUS  = 16'd1200;
  localparam logic [15:0] CLOSED_PENALTY = 16'd2500;
  localparam logic [15:0] RANK_MAX       = 16'd41033;

  // Weight of a node kind; unknown kinds weigh nothing.
  function automatic logic [15:0] kind_weight(input logic [3:0] kind);
    logic [15:0] w;
    unique case (kind)
      4'd0:    w = 16'd6000;
      4'd1:    w = 16'd6500;
      4'd2:    w = 16'd9000;
      4'd3:    w = 16'd8500;
      4'd4:    w = 16'd8000;
      4'd5:    w = 16'd7200;
      4'd6:    w = 16'd6900;
      4'd7:    w = 16'd7600;
      4'd8:    w = 16'd5400;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

  // Kind weight plus flag terms; the closed penalty never drives it below zero.
  function automatic logic [15:0] base_rank(input logic [3:0] kind, input logic [2:0] flags);
    logic [15:0] r;
    r = kind_weight(kind);
    if (flags[0]) r = r + OPEN_BONUS;
    if (flags[1]) r = r + BLOCKED_BONUS;
    if (flags[2] && (r >= CLOSED_PENALTY)) r = r - CLOSED_PENALTY;
    return r;
  endfunction

endpackage

/* rtl/rntk_ctrl.sv */
// Controller state machine: sequences rank steps, list insertion and the emit run.
module rntk_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic                  live,
  input  rntk_pkg::rntk_status_t status,
  output rntk_pkg::rntk_cmd_t    cmd
);
  import rntk_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_INSERT = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [2:0] step, step_next;
  logic       accept;

  // Items are taken only while no offer or emit run is in progress.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (mode == MODE_START) begin
            cmd.clear = 1'b1;
          end else if ((mode == MODE_OFFER) && live) begin
            cmd.capture = 1'b1;
            step_next   = STEP_CONF;
            state_next  = S_CALC;
          end else if (mode == MODE_FINISH) begin
            cmd.emit_start = 1'b1;
            state_next     = S_EMIT;
          end else begin
            // Dead nodes and the unused mode code leave everything alone.
            state_next = S_IDLE;
          end
        end
      end
      S_CALC: begin
        // Step n converts fraction n while the term of fraction n-1 is summed.
        cmd.step   = step;
        cmd.bp_en  = (step != STEP_LAST);
        cmd.acc_en = (step != STEP_CONF);
        if (step == STEP_LAST) begin
          state_next = S_INSERT;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.at_last) state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= STEP_CONF;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

/* rtl/rntk_datapath.sv */
// Datapath: rank unit, sorted list of kept entries, keep limit and output register.
module rntk_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rntk_pkg::in_item_t     in_item,
  input  logic                   cfg_we,
  input  logic [4:0]             cfg_wdata,
  input  rntk_pkg::rntk_cmd_t    cmd,
  output rntk_pkg::rntk_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rntk_pkg::out_item_t    out_item
);
  import rntk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LIMIT_WIDTH-1:0] keep_limit;
  in_item_t               item_q;
  logic [15:0]            acc;
  logic [13:0]            bp_q;
  logic [2:0]             sel_q;

  logic [15:0] kept_rank  [DEPTH];
  logic [31:0] kept_index [DEPTH];
  logic [CW-1:0] kept_count;
  logic          dropped_mark;
  logic [CW-1:0] ptr;

  // Keep limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      keep_limit <= cfg_wdata;
    end
  end

  // Offered node is held for the rank steps.
  always_ff @(posedge clk) begin
    if (cmd.capture) item_q <= in_item;
  end

  // Fraction of the current step.
  logic [16:0] frac;
  always_comb begin
    unique case (cmd.step)
      STEP_CONF: frac = item_q.confidence;
      STEP_UTIL: frac = item_q.utility;
      STEP_NOV:  frac = item_q.novelty;
      STEP_RISK: frac = item_q.risk;
      STEP_COST: frac = item_q.cost;
      default:   frac = '0;
    endcase
  end

  // Fraction to basis points, rounded half up; 1.0 and above saturate.
  logic [29:0] bp_prod;
  logic [29:0] bp_round;
  logic [13:0] bp_next;
  assign bp_prod  = 30'(frac[15:0]) * 30'(BP_FULL);
  assign bp_round = bp_prod + BP_ROUND;
  assign bp_next  = frac[16] ? BP_FULL : bp_round[29:16];

  always_ff @(posedge clk) begin
    if (cmd.bp_en) begin
      bp_q  <= bp_next;
      sel_q <= cmd.step;
    end
  end

  // Rank term of the registered basis points.
  logic [13:0] comp;
  logic [29:0] third_prod;
  logic [15:0] term;
  assign comp       = BP_FULL - bp_q;
  assign third_prod = 30'(comp) * 30'(THIRD_RECIP);

  always_comb begin
    unique case (sel_q)
      STEP_CONF: term = {3'b000, bp_q[13:1]};
      STEP_UTIL: term = {2'b00, bp_q};
      STEP_NOV:  term = {3'b000, bp_q[13:1]};
      STEP_RISK: term = {2'b00, third_prod[29:16]};
      STEP_COST: term = {4'b0000, comp[13:2]};
      default:   term = '0;
    endcase
  end

  // Rank accumulator, seeded with the kind weight and flag terms.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= base_rank(in_item.kind, in_item.flags);
    end else if (cmd.acc_en) begin
      acc <= acc + term;
    end
  end

  // Effective limit: values above the list depth act as the depth.
  logic [CW-1:0] lim;
  always_comb begin
    if (32'(keep_limit) > DEPTH) begin
      lim = CW'(DEPTH);
    end else begin
      lim = CW'(keep_limit);
    end
  end

  logic          lim_zero;
  logic          full;
  logic [CW-1:0] n_keep;
  logic [DEPTH-1:0] beats;
  logic [DEPTH-1:0] go;
  logic [DEPTH-1:0] at_worst;
  logic          accept_node;
  logic          do_insert;

  assign lim_zero    = (lim == '0);
  assign full        = (kept_count >= lim);
  // Entries that survive: a full list loses its worst entry.
  assign n_keep      = full ? (lim - CW'(1)) : kept_count;
  assign accept_node = !lim_zero && (!full || (|at_worst));
  assign do_insert   = cmd.insert && accept_node;

  // Every slot compares against the new node at once and shifts down if beaten.
  for (genvar j = 0; j < DEPTH; j++) begin : g_slot
    assign beats[j]    = (acc > kept_rank[j]) ||
                         ((acc == kept_rank[j]) && (item_q.node_index < kept_index[j]));
    assign go[j]       = (n_keep > CW'(j)) && beats[j];
    assign at_worst[j] = beats[j] && (lim == CW'(j + 1));

    if (j == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_insert && (go[j] || (n_keep == CW'(j)))) begin
          kept_rank[j]  <= acc;
          kept_index[j] <= item_q.node_index;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (go[j-1]) begin
            kept_rank[j]  <= kept_rank[j-1];
            kept_index[j] <= kept_index[j-1];
          end else if (go[j] || (n_keep == CW'(j))) begin
            kept_rank[j]  <= acc;
            kept_index[j] <= item_q.node_index;
          end
        end
      end
    end
  end

  // Fill count and truncation mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count   <= '0;
      dropped_mark <= 1'b0;
    end else if (cmd.clear) begin
      kept_count   <= '0;
      dropped_mark <= 1'b0;
    end else if (cmd.insert) begin
      if (lim_zero || full) dropped_mark <= 1'b1;
      if (accept_node) kept_count <= full ? lim : (kept_count + CW'(1));
    end
  end

  // Emit pointer walks the list from the best entry down.
  logic [CW-1:0] ptr_inc;
  assign ptr_inc = ptr + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.emit_start) begin
      ptr <= '0;
    end else if (cmd.emit_load) begin
      ptr <= ptr_inc;
    end
  end

  assign status.out_free = !out_valid || !out_stall;
  assign status.at_last  = (kept_count == '0) || (ptr_inc >= kept_count);

  // Output register; an empty list yields a single blank item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_item.valid_res <= (kept_count != '0);
      out_item.out_index <= (kept_count != '0) ? kept_index[ptr[IW-1:0]] : 32'd0;
      out_item.out_rank  <= (kept_count != '0) ? kept_rank[ptr[IW-1:0]] : 16'd0;
      out_item.truncated <= dropped_mark;
      out_item.last      <= status.at_last;
    end
  end

endmodule

/* rtl/ranked_node_top_k.sv */
// Top level of the ranked node top-k selector.
// Scores each live offered node and keeps the best entries, highest rank first and the
// lower node index first on equal rank, in a sorted register list of DEPTH slots that
// shifts all slots at once. A start item and any item that causes no work leave the
// controller idle. An offer of a live node is accepted, then passes the rank steps of
// the rank unit (one shared multiplier converts one fraction to basis points per cycle,
// and the next cycle adds its term), and then the parallel compare and shift of the
// list. A finish item yields max(1, kept entries) result items, each launched as soon
// as the output register is free; the list stays intact for a later finish. The next
// input item is taken once the last result of a finish run sits in the output
// register, even while it waits to be taken.
module ranked_node_top_k #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rntk_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rntk_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);
  import rntk_pkg::*;

  rntk_cmd_t    cmd;
  rntk_status_t status;

  // Sequencer for rank steps, insertion and emit runs.
  rntk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (in_item.mode),
    .live     (in_item.live),
    .status   (status),
    .cmd      (cmd)
  );

  // Rank unit, kept list and output register.
  rntk_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/rntk_checker.sv */
// Port-level checker for the ranked node top-k selector and its bind.
`include "ranked_node_top_k_macros.svh"

module rntk_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rntk_pkg::out_item_t out_item
);
  import rntk_pkg::*;

  logic        in_run;
  logic [15:0] prev_rank;
  logic        unused_in;

  assign unused_in = in_valid ^ in_stall;

  // Track whether the last taken item was a non-final item of a finish run.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (out_valid && !out_stall) begin
      in_run <= !out_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall && !unused_in) prev_rank <= out_item.out_rank;
    else if (out_valid && !out_stall) prev_rank <= out_item.out_rank;
  end

  `RNTK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")
  `RNTK_ASSERT_IMPL(a_empty_alone, out_valid && !out_item.valid_res, out_item.last && (out_item.out_rank == 16'd0) && (out_item.out_index == 32'd0), "empty list item is not a lone blank item")
  `RNTK_ASSERT_IMPL(a_rank_max, out_valid, out_item.out_rank <= RANK_MAX, "result rank above the largest possible rank")
  `RNTK_ASSERT_IMPL(a_sorted, out_valid && in_run, out_item.valid_res && (out_item.out_rank <= prev_rank), "finish run is not sorted by rank")

endmodule

bind ranked_node_top_k rntk_checker u_rntk_checker (.*);
